// ===== hdl/tpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpsc_pkg
// Shared types and constants for the tape pulse snap cleaner.
// ----------------------------------------------------------------------------
package tpsc_pkg;

  localparam int unsigned PulseW    = 8;
  localparam int unsigned TolW      = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;
  // Limit is tolerance plus two, plus ten more in boost mode.
  localparam int unsigned LimitW    = 6;
  localparam int unsigned LimitBase = 2;
  localparam int unsigned BoostExtra = 10;

  typedef logic [PulseW-1:0] pulse_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHORT_IDEAL  = 3'd0,
    CFG_MEDIUM_IDEAL = 3'd1,
    CFG_LONG_IDEAL   = 3'd2,
    CFG_SPLIT_THRESH = 3'd3,
    CFG_THRESH_MODE  = 3'd4,
    CFG_TOLERANCE    = 3'd5,
    CFG_BOOST        = 3'd6
  } cfg_idx_t;

  // Settings handed from the register file to the snap logic.
  typedef struct packed {
    pulse_t            short_ideal;
    pulse_t            medium_ideal;
    pulse_t            long_ideal;
    pulse_t            split_threshold;
    logic              threshold_mode;
    logic [TolW-1:0]   tolerance;
    logic              boost;
  } cfg_t;

endpackage

// ===== hdl/tpsc_in_if.sv =====
// ----------------------------------------------------------------------------
// tpsc_in_if
// Input channel: one raw pulse width per transaction.
// ----------------------------------------------------------------------------
interface tpsc_in_if
  import tpsc_pkg::*;
();
  logic   valid;
  logic   ready;
  pulse_t pulse_in;

  modport source (output valid, output pulse_in, input ready);
  modport sink (input valid, input pulse_in, output ready);
endinterface

// ===== hdl/tpsc_out_if.sv =====
// ----------------------------------------------------------------------------
// tpsc_out_if
// Result channel: one cleaned pulse width per transaction.
// ----------------------------------------------------------------------------
interface tpsc_out_if
  import tpsc_pkg::*;
();
  logic   valid;
  logic   ready;
  pulse_t pulse_out;

  modport source (output valid, output pulse_out, input ready);
  modport sink (input valid, input pulse_out, output ready);
endinterface

// ===== hdl/tpsc_snap.sv =====
// ----------------------------------------------------------------------------
// tpsc_snap
// Snapping logic for one pulse: threshold mode or the closed form of the
// progressive tolerance passes.
// ----------------------------------------------------------------------------
module tpsc_snap
  import tpsc_pkg::*;
(
  input  cfg_t   cfg,
  input  pulse_t pulse,
  output pulse_t snapped
);

  pulse_t              ideal [3];
  logic   [2:0]        used;
  pulse_t              delta [3];
  logic   [PulseW:0]   delta_x [3];
  logic   [PulseW:0]   dmin;
  logic   [PulseW:0]   dthr;
  logic   [LimitW-1:0] span;
  logic   [LimitW-1:0] limit;
  logic   [2:0]        claim;
  logic   [PulseW:0]   long_reach;
  logic   [PulseW:0]   pulse_reach;
  pulse_t              pass_val;
  pulse_t              thr_val;

  assign ideal[0] = cfg.short_ideal;
  assign ideal[1] = cfg.medium_ideal;
  assign ideal[2] = cfg.long_ideal;

  // Distance to each ideal; an unused ideal sits out of reach.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      used[i]    = (ideal[i] != '0);
      delta[i]   = (pulse >= ideal[i]) ? pulse - ideal[i] : ideal[i] - pulse;
      delta_x[i] = used[i] ? {1'b0, delta[i]} : {1'b1, {PulseW{1'b0}}};
    end
  end

  // Widest distance the passes reach is limit minus two.
  assign span  = LimitW'(cfg.tolerance) + (cfg.boost ? LimitW'(BoostExtra) : '0);
  assign limit = span + LimitW'(LimitBase);

  // The first pass that finds a claimant settles the value for good, so only
  // the claim set at the nearest distance matters.
  always_comb begin
    dmin = delta_x[0];
    if (delta_x[1] < dmin) begin
      dmin = delta_x[1];
    end
    if (delta_x[2] < dmin) begin
      dmin = delta_x[2];
    end
    dthr = (dmin == '0) ? (PulseW+1)'(1) : dmin;
    for (int i = 0; i < 3; i++) begin
      claim[i] = used[i] && (delta_x[i] <= dthr);
    end

    pass_val = pulse;
    if (span != '0 && dmin <= (PulseW+1)'(span)) begin
      case (claim)
        3'b001: pass_val = ideal[0];
        3'b010: pass_val = ideal[1];
        3'b100: pass_val = ideal[2];
        3'b011: begin
          if (delta[0] < delta[1]) pass_val = ideal[0];
          else if (delta[1] < delta[0]) pass_val = ideal[1];
        end
        3'b110: begin
          if (delta[1] < delta[2]) pass_val = ideal[1];
          else if (delta[2] < delta[1]) pass_val = ideal[2];
        end
        3'b101: begin
          if (delta[0] < delta[2]) pass_val = ideal[0];
          else if (delta[2] < delta[0]) pass_val = ideal[2];
        end
        default: pass_val = pulse;
      endcase
    end
  end

  // Threshold mode: above the split snaps long if below long+limit, below it snaps short if above short-limit.
  assign long_reach  = {1'b0, cfg.long_ideal} + (PulseW+1)'(limit);
  assign pulse_reach = {1'b0, pulse} + (PulseW+1)'(limit);

  always_comb begin
    thr_val = pulse;
    if (pulse > cfg.split_threshold && {1'b0, pulse} < long_reach) begin
      thr_val = cfg.long_ideal;
    end else if (pulse < cfg.split_threshold &&
                 pulse_reach > {1'b0, cfg.short_ideal}) begin
      thr_val = cfg.short_ideal;
    end
  end

  assign snapped = cfg.threshold_mode ? thr_val : pass_val;

endmodule

// ===== hdl/tape_pulse_snap_cleaner_unit.sv =====
// ----------------------------------------------------------------------------
// tape_pulse_snap_cleaner_unit
// Cleans tape pulse widths by snapping them to configured ideal widths.
// ----------------------------------------------------------------------------
// The unit takes one pulse transaction per clock while in_ch.ready is high
// and returns one cleaned pulse per transaction, in order, through the input
// register and then the result register, with the snap logic in between.
// Each register advances when the one after it has room, so a full stream runs
// at one pulse per cycle as long as the result side keeps taking transactions.
// Configuration registers are written through cfg_we/cfg_idx/cfg_wdata and
// must only change while no pulse is in flight.
module tape_pulse_snap_cleaner_unit
  import tpsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  tpsc_in_if.sink             in_ch,
  tpsc_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  logic   s1_valid_r;
  pulse_t s1_pulse_r;
  logic   out_valid_r;
  pulse_t out_pulse_r;
  pulse_t snapped;
  logic   s1_ready;
  logic   out_ready;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SHORT_IDEAL:  cfg_r.short_ideal     <= cfg_wdata;
        CFG_MEDIUM_IDEAL: cfg_r.medium_ideal    <= cfg_wdata;
        CFG_LONG_IDEAL:   cfg_r.long_ideal      <= cfg_wdata;
        CFG_SPLIT_THRESH: cfg_r.split_threshold <= cfg_wdata;
        CFG_THRESH_MODE:  cfg_r.threshold_mode  <= cfg_wdata[0];
        CFG_TOLERANCE:    cfg_r.tolerance       <= cfg_wdata[TolW-1:0];
        CFG_BOOST:        cfg_r.boost           <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Each stage moves on when the stage after it has room.
  assign out_ready   = !out_valid_r || out_ch.ready;
  assign s1_ready    = !s1_valid_r || out_ready;
  assign in_ch.ready = s1_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_pulse_r <= in_ch.pulse_in;
    end
  end

  tpsc_snap u_snap (
    .cfg     (cfg_r),
    .pulse   (s1_pulse_r),
    .snapped (snapped)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_pulse_r <= snapped;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pulse_out = out_pulse_r;

endmodule
